FILE: rtl/spk_pkg.sv
// Shared types, constants and saturation helpers for the SPH pair kernel.
package spk_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_H  = 3'd0;
  localparam logic [2:0] REG_ND = 3'd1;
  localparam logic [2:0] REG_NP = 3'd2;
  localparam logic [2:0] REG_NV = 3'd3;
  localparam logic [2:0] REG_K  = 3'd4;
  localparam logic [2:0] REG_R0 = 3'd5;

  // Pipeline stage map: register stage numbers counted from the input.
  localparam int unsigned DIV_LAT = 34;
  localparam int unsigned ST_DIV1 = 4;
  localparam int unsigned ST_D1O  = ST_DIV1 + DIV_LAT;
  localparam int unsigned ST_DIV2 = ST_D1O + 5;
  localparam int unsigned ST_D2O  = ST_DIV2 + DIV_LAT;
  localparam int unsigned ST_OUT  = ST_D2O + 1;

  localparam logic signed [31:0] Q_MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN32 = 32'sh8000_0000;
  localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;
  localparam logic signed [32:0] Q_MAX33 = 33'sd2147483647;
  localparam logic signed [32:0] Q_MIN33 = -33'sd2147483648;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } sat_t;

  // Per-pair side data that travels along the whole pipeline.
  typedef struct packed {
    logic               self_p;
    logic               lt;
    logic               rho_ok;
    logic [30:0]        hd;
    logic [30:0]        dmax;
    logic [32:0]        den;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dvx;
    logic signed [31:0] dvy;
    logic signed [31:0] dens;
    logic               dsat;
    logic               fsat;
  } side_t;

  // Fixed point product: floor shift by the fraction width, then clip.
  function automatic sat_t qsat(input logic signed [63:0] p, input int unsigned frac);
    logic signed [63:0] sh;
    sat_t r;
    sh = p >>> frac;
    if (sh > Q_MAX64) begin
      r.sat = 1'b1;
      r.val = Q_MAX32;
    end else if (sh < Q_MIN64) begin
      r.sat = 1'b1;
      r.val = Q_MIN32;
    end else begin
      r.sat = 1'b0;
      r.val = sh[31:0];
    end
    return r;
  endfunction

  // Clip an exact 33-bit sum or difference to the 32-bit range.
  function automatic sat_t sat33(input logic signed [32:0] v);
    sat_t r;
    if (v > Q_MAX33) begin
      r.sat = 1'b1;
      r.val = Q_MAX32;
    end else if (v < Q_MIN33) begin
      r.sat = 1'b1;
      r.val = Q_MIN32;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/sph_pair_interaction_kernel.sv
// Top level of the SPH pair kernel: config registers, arithmetic pipeline and handshake.
//
// One neighbour pair enters per transaction on the input channel (in_valid_i with
// in_stall_o) and one result leaves per transaction on the output channel
// (out_valid_o with out_stall_i). A pair is taken whenever in_valid_i is high and
// in_stall_o is low, so a new pair can be accepted in every clock cycle.
// The pipeline depth is set by two chained 34-stage dividers that form one quotient
// bit per inner stage: the first divides by twice the target density, the second
// by the clipped distance. The multiplies around them each take a registered stage
// of their own.
// Throughput is one transaction per cycle for as long as the receiver keeps up.
// When a finished result waits with out_stall_i high, the whole pipeline holds
// in place and in_stall_o goes high; nothing is dropped or repeated.
// Reset empties the pipeline (all valid bits clear) and loads every register
// of the configuration port with 1.0 in fixed point. The APB port writes
// registers at byte addresses 4*i and always answers with pready high; it is
// meant to be written only while no transaction is in flight.
module sph_pair_interaction_kernel import spk_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Pair input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                same_particle_i,
  input  logic [30:0]         distance_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic signed [31:0]  delta_vx_i,
  input  logic signed [31:0]  delta_vy_i,
  input  logic signed [31:0]  density_source_i,
  input  logic signed [31:0]  density_target_i,
  // Result output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  density_term_o,
  output logic signed [31:0]  force_x_o,
  output logic signed [31:0]  force_y_o,
  output logic                saturated_o
);

  localparam int unsigned ONE  = 1 << FRAC_BITS;
  // Smallest distance used as a divisor: 0.001 rounded, at least one raw unit.
  localparam int unsigned EPS0 = (ONE + 500) / 1000;
  localparam int unsigned EPS  = (EPS0 < 1) ? 1 : EPS0;

  // Configuration registers.
  logic [30:0]        h_q, nd_q, k_q, r0_q;
  logic signed [31:0] np_q, nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= 31'(ONE);
      nd_q <= 31'(ONE);
      k_q  <= 31'(ONE);
      r0_q <= 31'(ONE);
      np_q <= 32'(ONE);
      nv_q <= 32'(ONE);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_H:   h_q  <= pwdata[30:0];
        REG_ND:  nd_q <= pwdata[30:0];
        REG_NP:  np_q <= pwdata;
        REG_NV:  nv_q <= pwdata;
        REG_K:   k_q  <= pwdata[30:0];
        REG_R0:  r0_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_H:   prdata = {1'b0, h_q};
      REG_ND:  prdata = {1'b0, nd_q};
      REG_NP:  prdata = np_q;
      REG_NV:  prdata = nv_q;
      REG_K:   prdata = {1'b0, k_q};
      REG_R0:  prdata = {1'b0, r0_q};
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // The pipeline moves as a whole unless the result at its end is held back.
  logic adv;
  logic vld_q [1:ST_OUT];

  assign adv        = !(vld_q[ST_OUT] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= ST_OUT; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= ST_OUT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Side data line. Stages that produce flags or late operands patch it in place.
  side_t side_q [1:ST_D2O];
  side_t side_n [1:ST_D2O-1];
  side_t side_in;
  sat_t  rt_s, rs_s;

  always_comb begin
    rt_s = sat33({density_target_i[31], density_target_i} - $signed({2'b0, r0_q}));
    rs_s = sat33({density_source_i[31], density_source_i} - $signed({2'b0, r0_q}));
    side_in.self_p = same_particle_i;
    side_in.lt     = distance_i < h_q;
    side_in.rho_ok = density_target_i > 32'sd0;
    side_in.hd     = h_q - distance_i;
    side_in.dmax   = (distance_i < 31'(EPS)) ? 31'(EPS) : distance_i;
    side_in.den    = {density_target_i, 1'b0};
    side_in.dx     = delta_x_i;
    side_in.dy     = delta_y_i;
    side_in.dvx    = delta_vx_i;
    side_in.dvy    = delta_vy_i;
    side_in.dens   = '0;
    side_in.dsat   = 1'b0;
    side_in.fsat   = rt_s.sat | rs_s.sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1] <= side_in;
    end
  end

  for (genvar k = 2; k <= ST_D2O; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_n[k-1];
      end
    end
  end

  // Arithmetic stage registers.
  logic [61:0]        hh_q, dsq_q, m1_q;
  logic signed [63:0] ptp_q, psp_q, pnp_q, m2_q, m3_q;
  logic [30:0]        s2_q, s3_q, s4_q;
  logic signed [31:0] pt_q, ps_q, a_q;
  logic signed [63:0] p1_q, pv_q, p2_q, pvx_q, pvy_q, pfx_q, pfy_q;
  logic signed [31:0] vis_q, f_q, nx_q, ny_q;

  logic [61:0] sq_diff, sq_sh;
  logic        sq_sat;
  logic [30:0] sq_val;
  sat_t pt_s, ps_s, psum_s, m1_s, pnp_s, m2_s, m3_s;
  sat_t p1_s, pv_s, p2_s, pvx_s, pvy_s, pfx_s, pfy_s, fx_s, fy_s;
  sat_t d1, d2, d3, d4;

  always_comb begin
    sq_diff = hh_q - dsq_q;
    sq_sh   = sq_diff >> FRAC_BITS;
    sq_sat  = |sq_sh[61:31];
    sq_val  = sq_sat ? '1 : sq_sh[30:0];
    pt_s    = qsat(ptp_q, FRAC_BITS);
    ps_s    = qsat(psp_q, FRAC_BITS);
    psum_s  = sat33({pt_q[31], pt_q} + {ps_q[31], ps_q});
    m1_s    = qsat($signed({2'b0, m1_q}), FRAC_BITS);
    pnp_s   = qsat(pnp_q, FRAC_BITS);
    m2_s    = qsat(m2_q, FRAC_BITS);
    m3_s    = qsat(m3_q, FRAC_BITS);
    p1_s    = qsat(p1_q, FRAC_BITS);
    pv_s    = qsat(pv_q, FRAC_BITS);
    p2_s    = qsat(p2_q, FRAC_BITS);
    pvx_s   = qsat(pvx_q, FRAC_BITS);
    pvy_s   = qsat(pvy_q, FRAC_BITS);
    pfx_s   = qsat(pfx_q, FRAC_BITS);
    pfy_s   = qsat(pfy_q, FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Squares of h and d, and both particle pressures.
      hh_q  <= h_q * h_q;
      dsq_q <= distance_i * distance_i;
      ptp_q <= $signed({1'b0, k_q}) * rt_s.val;
      psp_q <= $signed({1'b0, k_q}) * rs_s.val;
      // Density chain: norm * s * s * s.
      s2_q  <= sq_val;
      pt_q  <= pt_s.val;
      ps_q  <= ps_s.val;
      s3_q  <= s2_q;
      m1_q  <= nd_q * s2_q;
      pnp_q <= np_q * psum_s.val;
      s4_q  <= s3_q;
      m2_q  <= m1_s.val * $signed({1'b0, s3_q});
      a_q   <= pnp_s.val;
      m3_q  <= m2_s.val * $signed({1'b0, s4_q});
      // After the first dividers: pressure scale and viscous scale times (h-d).
      p1_q  <= d1.val * $signed({1'b0, side_q[ST_D1O].hd});
      pv_q  <= d2.val * $signed({1'b0, side_q[ST_D1O].hd});
      p2_q  <= p1_s.val * $signed({1'b0, side_q[ST_D1O+1].hd});
      vis_q <= pv_s.val;
      f_q   <= p2_s.val;
      pvx_q <= vis_q * side_q[ST_D1O+2].dvx;
      pvy_q <= vis_q * side_q[ST_D1O+2].dvy;
      pfx_q <= f_q * side_q[ST_D1O+3].dx;
      pfy_q <= f_q * side_q[ST_D1O+3].dy;
      nx_q  <= pfx_s.val;
      ny_q  <= pfy_s.val;
    end
  end

  always_comb begin
    for (int k = 1; k < ST_D2O; k++) side_n[k] = side_q[k];
    side_n[1].dsat = side_q[1].dsat | sq_sat;
    side_n[1].fsat = side_q[1].fsat | pt_s.sat | ps_s.sat;
    side_n[2].fsat = side_q[2].fsat | psum_s.sat;
    side_n[3].dsat = side_q[3].dsat | m1_s.sat;
    side_n[3].fsat = side_q[3].fsat | pnp_s.sat;
    side_n[4].dsat = side_q[4].dsat | m2_s.sat;
    side_n[5].dens = m3_s.val;
    side_n[5].dsat = side_q[5].dsat | m3_s.sat;
    side_n[ST_D1O].fsat   = side_q[ST_D1O].fsat | d1.sat | d2.sat;
    side_n[ST_D1O+1].fsat = side_q[ST_D1O+1].fsat | p1_s.sat | pv_s.sat;
    side_n[ST_D1O+2].fsat = side_q[ST_D1O+2].fsat | p2_s.sat;
    // The viscous terms take the place of the velocity differences.
    side_n[ST_D1O+3].dvx  = pvx_s.val;
    side_n[ST_D1O+3].dvy  = pvy_s.val;
    side_n[ST_D1O+3].fsat = side_q[ST_D1O+3].fsat | pvx_s.sat | pvy_s.sat;
    side_n[ST_D1O+4].fsat = side_q[ST_D1O+4].fsat | pfx_s.sat | pfy_s.sat;
  end

  // First pair of dividers share the denominator 2*rho_target.
  spk_div #(.FRAC_BITS(FRAC_BITS)) u_div_p (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (a_q),
    .den_i (side_q[ST_DIV1].den),
    .quo_o (d1)
  );

  spk_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nv_q),
    .den_i (side_q[ST_DIV1].den),
    .quo_o (d2)
  );

  // Second pair divides the pressure force components by the clipped distance.
  spk_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nx_q),
    .den_i ({2'b0, side_q[ST_DIV2].dmax}),
    .quo_o (d3)
  );

  spk_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (ny_q),
    .den_i ({2'b0, side_q[ST_DIV2].dmax}),
    .quo_o (d4)
  );

  // Final sum and selection of the special cases.
  side_t sv;
  logic  force_ok;
  logic  sat_all;

  always_comb begin
    sv       = side_q[ST_D2O];
    fx_s     = sat33({d3.val[31], d3.val} + {sv.dvx[31], sv.dvx});
    fy_s     = sat33({d4.val[31], d4.val} + {sv.dvy[31], sv.dvy});
    force_ok = sv.lt && !sv.self_p && sv.rho_ok;
    // Out of range pairs report nothing; a non-positive target density is flagged for a distinct pair.
    sat_all  = sv.lt && (sv.dsat || (!sv.self_p && (!sv.rho_ok || sv.fsat || d3.sat ||
               d4.sat || fx_s.sat || fy_s.sat)));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      density_term_o <= sv.lt ? sv.dens : '0;
      force_x_o      <= force_ok ? fx_s.val : '0;
      force_y_o      <= force_ok ? fy_s.val : '0;
      saturated_o    <= sat_all;
    end
  end

  assign out_valid_o = vld_q[ST_OUT];

endmodule

FILE: rtl/spk_div.sv
// Pipelined restoring divider: saturated (num * 2^F) / den, one quotient bit per stage.
module spk_div import spk_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] num_i,
  input  logic [32:0]        den_i,
  output sat_t               quo_o
);

  localparam int unsigned QB = 32;
  localparam int unsigned RW = 65;

  logic [RW-1:0] rem_q [0:QB];
  logic [32:0]   den_q [0:QB];
  logic [QB-1:0] quo_q [0:QB];
  logic          neg_q [0:QB];
  logic          ovf_q [0:QB];
  sat_t          out_q;

  logic [31:0]   mag;
  logic [RW-1:0] numx;
  logic          ovf;

  always_comb begin
    mag  = num_i[31] ? (~num_i + 32'd1) : num_i;
    numx = RW'(mag) << FRAC_BITS;
    ovf  = numx >= {den_i, 32'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= numx;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[31];
      ovf_q[0] <= ovf;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int unsigned B = QB - 1 - i;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den_q[i]) << B;
    assign ge  = rem_q[i] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? (rem_q[i] - dsh) : rem_q[i];
        quo_q[i+1] <= quo_q[i] | (QB'(ge) << B);
        den_q[i+1] <= den_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  sat_t res;
  logic [31:0] qm;

  always_comb begin
    qm = quo_q[QB];
    if (neg_q[QB]) begin
      if (ovf_q[QB] || (qm > 32'h8000_0000)) begin
        res.sat = 1'b1;
        res.val = Q_MIN32;
      end else begin
        res.sat = 1'b0;
        res.val = ~qm + 32'd1;
      end
    end else begin
      if (ovf_q[QB] || qm[31]) begin
        res.sat = 1'b1;
        res.val = Q_MAX32;
      end else begin
        res.sat = 1'b0;
        res.val = qm;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= res;
    end
  end

  assign quo_o = out_q;

endmodule

FILE: bench/spk_checker.sv
// Checker for the SPH pair kernel: mirrors the registers, predicts each result and compares.
module spk_checker import spk_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic               same_particle_i,
  input  logic [30:0]        distance_i,
  input  logic signed [31:0] delta_x_i,
  input  logic signed [31:0] delta_y_i,
  input  logic signed [31:0] delta_vx_i,
  input  logic signed [31:0] delta_vy_i,
  input  logic signed [31:0] density_source_i,
  input  logic signed [31:0] density_target_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic signed [31:0] density_term_o,
  input  logic signed [31:0] force_x_o,
  input  logic signed [31:0] force_y_o,
  input  logic               saturated_o,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] dens;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               sat;
  } kernel_out_t;

  localparam logic signed [63:0] ONE_RAW = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] EPS_Q = ((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;

  logic [30:0]        h_q, nd_q, k_q, r0_q;
  logic signed [31:0] np_q, nv_q;
  logic               clip_hit;
  kernel_out_t        expected_q[$];

  function automatic logic signed [63:0] clip(input logic signed [63:0] v);
    if (v > Q_MAX64) begin
      clip_hit = 1'b1;
      return Q_MAX64;
    end
    if (v < Q_MIN64) begin
      clip_hit = 1'b1;
      return Q_MIN64;
    end
    return v;
  endfunction

  // Product with floor rounding of the dropped fraction bits.
  function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] prod;
    prod = a * b;
    return clip(prod >>> FRAC_BITS);
  endfunction

  // Quotient truncated toward zero; den is always positive here.
  function automatic logic signed [63:0] fdiv(input logic signed [63:0] a,
                                               input logic signed [63:0] den);
    return clip((a * ONE_RAW) / den);
  endfunction

  function automatic kernel_out_t predict_pair(
    input logic sp, input logic [30:0] pair_d,
    input logic signed [31:0] dx, dy, dvx, dvy, rho_s, rho_t);
    kernel_out_t r;
    logic [63:0] hu, du, su;
    logic signed [63:0] s, hd, den, pt, ps, psum, f, dd, vis, px, py, eps;
    r = '0;
    clip_hit = 1'b0;
    hu = {33'b0, h_q};
    du = {33'b0, pair_d};
    if (du < hu) begin
      su = (hu * hu - du * du) >> FRAC_BITS;
      if (su > 64'h7FFF_FFFF) begin
        clip_hit = 1'b1;
        s = Q_MAX64;
      end else begin
        s = $signed(su);
      end
      r.dens = 32'(fmul(fmul(fmul($signed({33'b0, nd_q}), s), s), s));
      if (!sp) begin
        if (rho_t <= 0) begin
          clip_hit = 1'b1;
        end else begin
          hd = $signed(hu - du);
          den = 64'sd2 * rho_t;
          pt = fmul($signed({33'b0, k_q}), clip(rho_t - $signed({33'b0, r0_q})));
          ps = fmul($signed({33'b0, k_q}), clip(rho_s - $signed({33'b0, r0_q})));
          psum = clip(pt + ps);
          f = fmul(fmul(fdiv(fmul(np_q, psum), den), hd), hd);
          eps = (EPS_Q < 1) ? 64'sd1 : EPS_Q;
          dd = $signed(du);
          if (dd < eps) dd = eps;
          px = fdiv(fmul(f, dx), dd);
          py = fdiv(fmul(f, dy), dd);
          vis = fmul(fdiv(nv_q, den), hd);
          r.fx = 32'(clip(px + fmul(vis, dvx)));
          r.fy = 32'(clip(py + fmul(vis, dvy)));
        end
      end
    end
    r.sat = clip_hit;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kernel_out_t got, want;
    if (!rst_ni) begin
      h_q <= 31'(ONE_RAW); nd_q <= 31'(ONE_RAW); k_q <= 31'(ONE_RAW); r0_q <= 31'(ONE_RAW);
      np_q <= 32'(ONE_RAW); nv_q <= 32'(ONE_RAW);
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      // Register writes land at the access phase of the port.
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_H:   h_q  <= pwdata[30:0];
          REG_ND:  nd_q <= pwdata[30:0];
          REG_NP:  np_q <= pwdata;
          REG_NV:  nv_q <= pwdata;
          REG_K:   k_q  <= pwdata[30:0];
          REG_R0:  r0_q <= pwdata[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        expected_q.push_back(predict_pair(same_particle_i, distance_i, delta_x_i, delta_y_i,
                                          delta_vx_i, delta_vy_i, density_source_i,
                                          density_target_i));
      if (out_valid_o && !out_stall_i) begin
        got = '{density_term_o, force_x_o, force_y_o, saturated_o};
        if (expected_q.size() == 0) begin
          $error("result transaction arrived with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          if (got.dens != want.dens)
            $error("density_term expected %0d actual %0d", want.dens, got.dens);
          if (got.fx != want.fx)
            $error("force_x expected %0d actual %0d", want.fx, got.fx);
          if (got.fy != want.fy)
            $error("force_y expected %0d actual %0d", want.fy, got.fy);
          if (got.sat != want.sat)
            $error("saturated expected %0d actual %0d", want.sat, got.sat);
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Stimulus, idling and verdict for the SPH pair kernel regression.
module tb_top;
  import spk_pkg::*;

  // Index past the end of the register list; writes there must be ignored.
  localparam logic [2:0] REG_SPARE = 3'd6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_WAIT = 100;
  localparam int PHASE_ITEMS = 290;
  localparam logic [30:0] ONE = 31'h1_0000;
  localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  logic               clk_i, rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [CFG_AW-1:0]  paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid_i, in_stall_o, same_particle_i;
  logic [30:0]        distance_i;
  logic signed [31:0] delta_x_i, delta_y_i, delta_vx_i, delta_vy_i;
  logic signed [31:0] density_source_i, density_target_i;
  logic               out_valid_o, out_stall_i, saturated_o;
  logic signed [31:0] density_term_o, force_x_o, force_y_o;
  int                 fail_count, pending;

  // The stimulus keeps its own copy of h and rest density to aim distances
  // and densities where the kernel does interesting work.
  logic [30:0]        h_now, r0_now;
  bit                 quiet;     // no idling at all in the closing stretch
  bit                 hold_req;  // asks the receiver for one long hold-off

  sph_pair_interaction_kernel uut (.*);
  spk_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a run that stops moving for too long is a failure.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        idle = 0;
      else
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver side: random stall bursts, one long hold-off on request, and
  // none at all once the closing stretch has started.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_H) h_now = value[30:0];
    if (idx == REG_R0) r0_now = value[30:0];
  endtask

  task automatic load_config(input logic [30:0] h, nd, input logic [31:0] np, nv,
                             input logic [30:0] k, r0);
    write_reg(REG_H, {1'b0, h});
    write_reg(REG_ND, {1'b0, nd});
    write_reg(REG_NP, np);
    write_reg(REG_NV, nv);
    write_reg(REG_K, {1'b0, k});
    write_reg(REG_R0, {1'b0, r0});
  endtask

  // Offer one pair and hold it until the block takes it; returns at a falling edge.
  task automatic send_pair(input logic sp, input logic [30:0] d,
                           input logic signed [31:0] dx, dy, dvx, dvy, rs, rt);
    in_valid_i <= 1'b1;
    same_particle_i <= sp; distance_i <= d;
    delta_x_i <= dx; delta_y_i <= dy; delta_vx_i <= dvx; delta_vy_i <= dvy;
    density_source_i <= rs; density_target_i <= rt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Signed value with a random magnitude scale, so small and huge both appear.
  function automatic logic signed [31:0] scaled_rand();
    logic signed [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 3) == 0) return v;
    return v >>> $urandom_range(4, 24);
  endfunction

  task automatic send_random_pair();
    logic [30:0] d;
    logic signed [31:0] rs, rt;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 12 && h_now > 0) d = 31'($urandom_range(0, h_now - 1));
    else if (pick < 14) d = 31'($urandom_range(0, 100));
    else d = 31'($urandom());
    // Densities mostly near rest density; sometimes anywhere, zero or negative.
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      rs = $signed({1'b0, r0_now}) + scaled_rand();
      rt = $signed({1'b0, r0_now}) + scaled_rand();
    end else if (pick < 9) begin
      rs = $urandom();
      rt = $urandom();
    end else begin
      rs = scaled_rand();
      rt = -$signed({1'b0, 31'($urandom_range(0, 1000))});
    end
    send_pair($urandom_range(0, 15) == 0, d, scaled_rand(), scaled_rand(),
              scaled_rand(), scaled_rand(), rs, rt);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  // Wait until every result is back, then let the bench idle for good measure.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; same_particle_i = 1'b0; distance_i = '0;
    delta_x_i = '0; delta_y_i = '0; delta_vx_i = '0; delta_vy_i = '0;
    density_source_i = '0; density_target_i = '0;
    quiet = 1'b0; hold_req = 1'b0;
    h_now = ONE; r0_now = ONE;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pairs at the reset configuration (h = 1.0).
    send_pair(1'b0, 31'd0, 32'sh1_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh2_0000, 32'sh2_0000);
    send_pair(1'b0, ONE - 1, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX);
    send_pair(1'b0, ONE, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000,
              32'sh1_0000, 32'sh1_0000);
    send_pair(1'b0, U31_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
    send_pair(1'b1, 31'h8000, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX);
    // Target density zero and negative: no force, flag raised; then a tiny target with minimum source density.
    send_pair(1'b0, 31'h4000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000,
              32'sh1_0000, 32'sh0);
    send_pair(1'b0, 31'h4000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000,
              32'sh1_0000, S_MIN);
    send_pair(1'b0, 31'h4000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, S_MIN, 32'sd1);
    // Distances around the divide floor of 0.001.
    send_pair(1'b0, 31'd1, 32'sh100, 32'sh0, 32'sh0, 32'sh0, 32'sh3_0000, 32'sh3_0000);
    send_pair(1'b0, 31'd65, S_MIN, S_MAX, S_MIN, S_MAX, 32'sh3_0000, 32'sh3_0000);
    send_pair(1'b0, 31'd66, 32'sh7FF, -32'sh7FF, 32'sh0, 32'sh0, 32'sh3_0000, 32'sh3_0000);
    send_pair(1'b0, 31'd0, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX);
    send_pair(1'b0, 31'h7FFF, -32'sh1_0000, 32'sh8000, -32'sh4_0000, 32'sh2_0000,
              32'sh1_8000, 32'sh8000);
    drain();

    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: load_config(31'h4_0000, 31'h8000, -32'sh3_0000, 32'sh4000, 31'h2_0000, ONE);
        2: load_config(U31_MAX, U31_MAX, S_MAX, S_MIN, U31_MAX, U31_MAX);
        3: load_config(31'h0, 31'h0, 32'sh0, 32'sh0, 31'h0, 31'h0);
        4: load_config(31'h8000, 31'($urandom()), S_MIN, S_MAX, 31'h1999, 31'h0);
        5: load_config(31'h10_0000, ONE, 32'sh1_0000, 32'sh2_0000, 31'h8_0000, 31'h3_0000);
        default: load_config(31'($urandom_range(1, 32'h20_0000)), 31'($urandom()), $urandom(),
                             $urandom(), 31'($urandom()),
                             31'($urandom_range(0, 32'h10_0000)));
      endcase
      if (phase == 3) write_reg(REG_SPARE, 32'hFFFF_FFFF);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == PHASE_ITEMS - 100) quiet = 1'b1;
        // The receiver holds off while pairs keep coming, so the pipeline fills.
        if (phase == 1 && n == 100) hold_req = 1'b1;
        // The sender stops until every outstanding result has returned.
        if (phase == 2 && n == 150) begin
          in_valid_i <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
        send_random_pair();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
